// ===== rtl/bdll_pkg.sv =====
// bdll_pkg: sizes, command and status codes, and beat types for the
// bounded doubly linked list unit. Depends on nothing.
package bdll_pkg;

    // list sizing
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int LINK_W     = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(CAPACITY);

    // command codes
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_BACK   = 3'd3;
    localparam t_cmd CMD_REMOVE_VAL = 3'd4;
    localparam t_cmd CMD_READ_INDEX = 3'd5;
    localparam t_cmd CMD_CLEAR      = 3'd6;

    // status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_EMPTY    = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_RANGE    = 3'd4;

    // input beat
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] value;
        logic [3:0]  index;
    } t_in_beat;

    // result beat
    typedef struct packed {
        t_status     status;
        logic [31:0] data;
        logic [4:0]  size;
        logic        empty_res;
    } t_out_beat;

    // one word of the link memory
    typedef struct packed {
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_link;

endpackage

// ===== rtl/bdll_ram.sv =====
// bdll_ram: generic simple dual-port ram, one write and one registered read.
// Self-contained, no package needed.
module bdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bounded_doubly_linked_list_unit.sv =====
// Bounded doubly linked list: one command beat in, one result beat out.
// Clear/full/empty/range results load directly; push fills the new slot, then patches the
// old end if the list was not empty; pop unlinks the end entry; read-at-index follows links
// from the head; remove-by-value compares entries (one memory read each), then reports not
// found or unlinks the match. One command at a time: next beat taken the cycle after the
// result loads. Reset (sync, active low) empties the list; the memories are not cleared.
module bounded_doubly_linked_list_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bdll_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bdll_pkg::t_out_beat o_out_beat
);
    import bdll_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_NBWR = 4'd2;
    localparam logic [3:0] S_UL0  = 4'd3;
    localparam logic [3:0] S_UL1  = 4'd4;
    localparam logic [3:0] S_UL2  = 4'd5;
    localparam logic [3:0] S_UL3  = 4'd6;
    localparam logic [3:0] S_UL4  = 4'd7;
    localparam logic [3:0] S_WALK = 4'd8;
    localparam logic [3:0] S_LOOK = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]            r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [3:0]            r_idx, n_idx;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [LINK_W-1:0]     r_tail, n_tail;
    logic [CAPACITY-1:0]   r_free, n_free;
    logic [LINK_W-1:0]     r_count, n_count;
    logic [LINK_W-1:0]     r_cur, n_cur;
    logic [LINK_W-1:0]     r_slot, n_slot;
    logic [LINK_W-1:0]     r_p, n_p;
    logic [LINK_W-1:0]     r_n, n_n;
    logic [3:0]            r_step, n_step;
    t_status               r_status, n_status;
    logic [31:0]           r_data, n_data;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out, n_out;

    // memory ports
    logic                  data_we;
    logic [SLOT_W-1:0]     data_waddr;
    logic [DATA_WIDTH-1:0] data_wdata;
    logic [SLOT_W-1:0]     data_raddr;
    logic [DATA_WIDTH-1:0] data_rdata;
    logic                  link_we;
    logic [SLOT_W-1:0]     link_waddr;
    t_link                 link_wdata;
    logic [SLOT_W-1:0]     link_raddr;
    t_link                 link_rdata;

    logic [LINK_W-1:0]     free_slot;

    // lowest-numbered free slot, null when full
    function automatic logic [LINK_W-1:0] lowest_free(input logic [CAPACITY-1:0] map);
        logic [LINK_W-1:0] res;
        res = NIL_SLOT;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (map[k]) begin
                res = LINK_W'(k);
            end
        end
        return res;
    endfunction

    assign free_slot = lowest_free(r_free);

    bdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    bdll_ram #(.WIDTH(2 * LINK_W), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_idx       = r_idx;
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_count     = r_count;
        n_cur       = r_cur;
        n_slot      = r_slot;
        n_p         = r_p;
        n_n         = r_n;
        n_step      = r_step;
        n_status    = r_status;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        data_we     = 1'b0;
        data_waddr  = free_slot[SLOT_W-1:0];
        data_wdata  = r_val;
        data_raddr  = r_cur[SLOT_W-1:0];
        link_we     = 1'b0;
        link_waddr  = r_slot[SLOT_W-1:0];
        link_wdata  = '{next: NIL_SLOT, prev: NIL_SLOT};
        link_raddr  = r_cur[SLOT_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_beat.cmd;
                    n_val   = i_in_beat.value[DATA_WIDTH-1:0];
                    n_idx   = i_in_beat.index;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status = ST_OK;
                n_data   = '0;
                n_state  = S_DONE;
                unique case (r_cmd) inside
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (free_slot == NIL_SLOT) begin
                            n_status = ST_FULL;
                        end else begin
                            // new entry into the lowest free slot
                            data_we    = 1'b1;
                            link_we    = 1'b1;
                            link_waddr = free_slot[SLOT_W-1:0];
                            n_free[free_slot[SLOT_W-1:0]] = 1'b0;
                            n_count    = r_count + 1'b1;
                            n_slot     = free_slot;
                            if (r_head == NIL_SLOT) begin
                                n_head = free_slot;
                                n_tail = free_slot;
                            end else if (r_cmd == CMD_PUSH_FRONT) begin
                                link_wdata = '{next: r_head, prev: NIL_SLOT};
                                link_raddr = r_head[SLOT_W-1:0];
                                n_cur      = r_head;
                                n_head     = free_slot;
                                n_state    = S_NBWR;
                            end else begin
                                link_wdata = '{next: NIL_SLOT, prev: r_tail};
                                link_raddr = r_tail[SLOT_W-1:0];
                                n_cur      = r_tail;
                                n_tail     = free_slot;
                                n_state    = S_NBWR;
                            end
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (r_head == NIL_SLOT) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_slot  = (r_cmd == CMD_POP_FRONT) ? r_head : r_tail;
                            n_state = S_UL0;
                        end
                    end
                    CMD_REMOVE_VAL: begin
                        if (r_head == NIL_SLOT) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_cur   = r_head;
                            n_state = S_WALK;
                        end
                    end
                    CMD_READ_INDEX: begin
                        if (32'(r_idx) >= 32'(r_count)) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_cur   = r_head;
                            n_step  = r_idx;
                            n_state = S_WALK;
                        end
                    end
                    CMD_CLEAR: begin
                        n_free  = '1;
                        n_head  = NIL_SLOT;
                        n_tail  = NIL_SLOT;
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end

            // patch the old end entry to point at the new slot
            S_NBWR: begin
                link_we    = 1'b1;
                link_waddr = r_cur[SLOT_W-1:0];
                if (r_cmd == CMD_PUSH_FRONT) begin
                    link_wdata = '{next: link_rdata.next, prev: r_slot};
                end else begin
                    link_wdata = '{next: r_slot, prev: link_rdata.prev};
                end
                n_state = S_DONE;
            end

            // unlink: fetch links of the victim slot
            S_UL0: begin
                link_raddr = r_slot[SLOT_W-1:0];
                n_state    = S_UL1;
            end

            S_UL1: begin
                n_p = link_rdata.prev;
                n_n = link_rdata.next;
                n_free[r_slot[SLOT_W-1:0]] = 1'b1;
                n_count = r_count - 1'b1;
                if (link_rdata.prev != NIL_SLOT) begin
                    link_raddr = link_rdata.prev[SLOT_W-1:0];
                    n_state    = S_UL2;
                end else begin
                    n_head  = link_rdata.next;
                    n_state = S_UL3;
                end
            end

            // predecessor skips the victim
            S_UL2: begin
                link_we    = 1'b1;
                link_waddr = r_p[SLOT_W-1:0];
                link_wdata = '{next: r_n, prev: link_rdata.prev};
                n_state    = S_UL3;
            end

            S_UL3: begin
                if (r_n != NIL_SLOT) begin
                    link_raddr = r_n[SLOT_W-1:0];
                    n_state    = S_UL4;
                end else begin
                    n_tail  = r_p;
                    n_state = S_DONE;
                end
            end

            // successor points back past the victim
            S_UL4: begin
                link_we    = 1'b1;
                link_waddr = r_n[SLOT_W-1:0];
                link_wdata = '{next: link_rdata.next, prev: r_p};
                n_state    = S_DONE;
            end

            // walk: read data and links of the current slot
            S_WALK: begin
                n_state = S_LOOK;
            end

            S_LOOK: begin
                if (r_cmd == CMD_REMOVE_VAL) begin
                    if (data_rdata == r_val) begin
                        n_slot  = r_cur;
                        n_state = S_UL0;
                    end else if (link_rdata.next == NIL_SLOT) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_cur   = link_rdata.next;
                        n_state = S_WALK;
                    end
                end else begin
                    if (r_step == '0) begin
                        n_data  = 32'(data_rdata);
                        n_state = S_DONE;
                    end else begin
                        n_cur   = link_rdata.next;
                        n_step  = r_step - 1'b1;
                        n_state = S_WALK;
                    end
                end
            end

            // load the result register once it is free
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status    = r_status;
                    n_out.data      = r_data;
                    n_out.size      = 5'(r_count);
                    n_out.empty_res = (r_count == '0);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL_SLOT;
            r_tail      <= NIL_SLOT;
            r_free      <= '1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_slot   <= n_slot;
        r_p      <= n_p;
        r_n      <= n_n;
        r_step   <= n_step;
        r_status <= n_status;
        r_data   <= n_data;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
